@@ hw/rtl/cell_voltage_scan_aggregator_macros.svh @@
// Assertion macros for the cell voltage scan aggregator.
// Both macros expect clk_i and rst_ni to be visible where they are used.
`ifndef CELL_VOLTAGE_SCAN_AGGREGATOR_MACROS_SVH
`define CELL_VOLTAGE_SCAN_AGGREGATOR_MACROS_SVH

// Checked at every rising edge outside reset.
`define CVSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CVSA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/cvsa_pkg.sv @@
// Shared widths and constants of the cell voltage scan aggregator.
// Used by the channel interfaces and the top level; depends on nothing.
package cvsa_pkg;

  localparam int BoardW   = 3;
  localparam int CellW    = 5;
  localparam int CodeW    = 16;
  localparam int CurW     = 21;
  localparam int LimitW   = 20;
  localparam int VoltW    = 17;
  localparam int SumW     = 24;
  localparam int IdxWideW = 9;

  localparam int BoardCount    = 8;
  localparam int CellsPerBoard = 18;

  localparam logic signed [VoltW-1:0] VoltOffset = 17'sd10000;
  localparam logic [LimitW-1:0]       LimitReset = 20'd200;

endpackage

@@ hw/rtl/cvsa_in_if.sv @@
// Reading channel: one cell reading per transaction with valid/ready.
// Depends on cvsa_pkg for the field widths.
interface cvsa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [cvsa_pkg::BoardW-1:0]          board_index;
  logic [cvsa_pkg::CellW-1:0]           cell_index;
  logic signed [cvsa_pkg::CodeW-1:0]    raw_code;
  logic signed [cvsa_pkg::CurW-1:0]     pack_current;
  logic                                 last_reading;

  modport source (output valid, board_index, cell_index, raw_code, pack_current,
                  last_reading, input ready);
  modport sink   (input valid, board_index, cell_index, raw_code, pack_current,
                  last_reading, output ready);
endinterface

@@ hw/rtl/cvsa_out_if.sv @@
// Result channel: one aggregated result per transaction with valid/ready.
// Depends on cvsa_pkg for the field widths.
interface cvsa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cvsa_pkg::VoltW-1:0] cell_volts;
  logic signed [cvsa_pkg::SumW-1:0]  pack_sum;
  logic signed [cvsa_pkg::VoltW-1:0] scan_min;
  logic signed [cvsa_pkg::VoltW-1:0] scan_max;
  logic signed [cvsa_pkg::VoltW-1:0] open_circuit_volts;
  logic                              scan_done;

  modport source (output valid, cell_volts, pack_sum, scan_min, scan_max,
                  open_circuit_volts, scan_done, input ready);
  modport sink   (input valid, cell_volts, pack_sum, scan_min, scan_max,
                  open_circuit_volts, scan_done, output ready);
endinterface

@@ hw/rtl/cell_voltage_scan_aggregator.sv @@
// Cell voltage scan aggregator: scan sum, minimum, maximum and open-circuit store.
// Depends on cvsa_pkg, cvsa_in_if, cvsa_out_if and the assertion macro header.
//
// Channel     | Direction | Carries
// reading_i   | in        | board, cell, ADC code, pack current, last flag
// result_o    | out       | volts, pack sum, scan min/max, open-circuit volts, done
// cfg_*_i     | in        | open-circuit current limit, written directly
//
// One transaction per cycle is accepted unless the result stalls; its result is registered.
// The store is a single-port-write memory of BoardCount*CellsPerBoard entries with a
// registered read; reads and writes of one reading happen in its acceptance cycle.
// Reset clears the accumulators and the store's valid bits at once, with no sweep.
// When the result is stalled, the reading channel is held off in the same cycle.
`include "cell_voltage_scan_aggregator_macros.svh"

module cell_voltage_scan_aggregator #(
  parameter int BoardCount    = cvsa_pkg::BoardCount,
  parameter int CellsPerBoard = cvsa_pkg::CellsPerBoard
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cvsa_in_if.sink                       reading_i,
  cvsa_out_if.source                    result_o,
  input  logic                          cfg_we_i,
  input  logic [cvsa_pkg::LimitW-1:0]   cfg_wdata_i
);

  localparam int Depth = BoardCount * CellsPerBoard;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int VW    = cvsa_pkg::VoltW;
  localparam int SW    = cvsa_pkg::SumW;
  localparam int IWW   = cvsa_pkg::IdxWideW;

  logic [cvsa_pkg::LimitW-1:0] limit_q;

  logic signed [SW-1:0] sum_q, sum_d;
  logic signed [VW-1:0] min_q, min_d, max_q, max_d;
  logic                 started_q, started_d;

  logic                 accept;
  logic signed [VW-1:0] volts;
  logic signed [SW-1:0] sum_new;
  logic signed [VW-1:0] min_new, max_new;
  logic [cvsa_pkg::CurW-1:0] cur_mag;
  logic                 snap, in_range, wr_en;
  logic [IWW-1:0]       idx_wide;
  logic [IdxW-1:0]      idx;

  logic [VW-1:0]        mem_q [Depth];
  logic [Depth-1:0]     vld_q;
  logic [VW-1:0]        rd_data_q;
  logic                 rd_vld_q;

  logic                 s1_valid_q;
  logic signed [VW-1:0] s1_volts_q, s1_min_q, s1_max_q;
  logic signed [SW-1:0] s1_sum_q;
  logic                 s1_inr_q, s1_snap_q, s1_last_q;

  assign reading_i.ready = !s1_valid_q || result_o.ready;
  assign accept          = reading_i.valid && reading_i.ready;

  always_comb begin
    volts    = VW'(reading_i.raw_code) + cvsa_pkg::VoltOffset;
    cur_mag  = reading_i.pack_current[cvsa_pkg::CurW-1] ?
               (~reading_i.pack_current + 1'b1) : reading_i.pack_current;
    snap     = cur_mag < {1'b0, limit_q};
    in_range = (32'(reading_i.board_index) < BoardCount) &&
               (32'(reading_i.cell_index) < CellsPerBoard);
    idx_wide = IWW'(reading_i.board_index) * IWW'(CellsPerBoard) +
               IWW'(reading_i.cell_index);
    idx      = idx_wide[IdxW-1:0];
    wr_en    = accept && in_range && snap;

    sum_new  = sum_q + SW'(volts);
    if (!started_q) begin
      min_new = volts;
      max_new = volts;
    end else begin
      min_new = (volts < min_q) ? volts : min_q;
      max_new = (volts > max_q) ? volts : max_q;
    end

    sum_d     = sum_q;
    min_d     = min_q;
    max_d     = max_q;
    started_d = started_q;
    if (accept) begin
      if (reading_i.last_reading) begin
        sum_d     = '0;
        min_d     = '0;
        max_d     = '0;
        started_d = 1'b0;
      end else begin
        sum_d     = sum_new;
        min_d     = min_new;
        max_d     = max_new;
        started_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= cvsa_pkg::LimitReset;
      sum_q      <= '0;
      min_q      <= '0;
      max_q      <= '0;
      started_q  <= 1'b0;
      vld_q      <= '0;
      rd_vld_q   <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      sum_q     <= sum_d;
      min_q     <= min_d;
      max_q     <= max_d;
      started_q <= started_d;
      if (wr_en) begin
        vld_q[idx] <= 1'b1;
      end
      if (accept) begin
        rd_vld_q   <= vld_q[idx];
        s1_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Store entry written and read in the cycle of acceptance; the read sees earlier writes.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[idx] <= volts;
    end
    if (accept) begin
      rd_data_q <= mem_q[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_volts_q <= volts;
      s1_sum_q   <= sum_new;
      s1_min_q   <= min_new;
      s1_max_q   <= max_new;
      s1_inr_q   <= in_range;
      s1_snap_q  <= snap;
      s1_last_q  <= reading_i.last_reading;
    end
  end

  assign result_o.valid      = s1_valid_q;
  assign result_o.cell_volts = s1_volts_q;
  assign result_o.pack_sum   = s1_sum_q;
  assign result_o.scan_min   = s1_min_q;
  assign result_o.scan_max   = s1_max_q;
  assign result_o.scan_done  = s1_last_q;

  always_comb begin
    if (!s1_inr_q) begin
      result_o.open_circuit_volts = '0;
    end else if (s1_snap_q) begin
      result_o.open_circuit_volts = s1_volts_q;
    end else if (rd_vld_q) begin
      result_o.open_circuit_volts = rd_data_q;
    end else begin
      result_o.open_circuit_volts = '0;
    end
  end

  `CVSA_ASSERT(a_last_closes_scan, accept && reading_i.last_reading |=> !started_q, "scan not closed after last reading")
  `CVSA_ASSERT(a_nonlast_opens_scan, accept && !reading_i.last_reading |=> started_q, "scan not open after a reading")
  `CVSA_ASSERT(a_min_le_max, started_q |-> (min_q <= max_q), "scan minimum above maximum")
  `CVSA_ASSERT(a_stall_holds_read, s1_valid_q && !result_o.ready |=> $stable(rd_data_q) && $stable(rd_vld_q), "store read data changed under stall")
  `CVSA_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |-> !s1_valid_q, "result valid during reset")

endmodule
